/* rtl/core/pfc_pkg.sv */
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, constants and key-square helper functions for the Playfair
// digraph cipher.
// ----------------------------------------------------------------------------
package pfc_pkg;

	localparam int CharW    = 8;
	localparam int CodeW    = 5;
	localparam int Side     = 5;
	localparam int Cells    = Side * Side;
	localparam int SqW      = Cells * CodeW;
	localparam int HalfW    = 60;
	localparam int MaxRes   = 4;
	localparam int CntW     = $clog2(MaxRes + 1);
	localparam int IdxW     = $clog2(MaxRes);
	localparam int DataW    = 64;
	localparam int AddrW    = 5;

	localparam logic [CharW-1:0] AsciiA   = 8'd97;
	localparam logic [CharW-1:0] AsciiZ   = 8'd122;
	localparam logic [CodeW-1:0] LetterX  = 5'd23;
	localparam logic [CodeW-1:0] LetterJ  = 5'd9;
	localparam logic [CodeW-1:0] LetterI  = 5'd8;
	localparam logic [CodeW-1:0] NoCell   = 5'd25;

	// register indexes, taken from paddr[4:3]
	localparam logic [1:0] RegMode = 2'd0;
	localparam logic [1:0] RegLow  = 2'd1;
	localparam logic [1:0] RegMid  = 2'd2;
	localparam logic [1:0] RegLast = 2'd3;

	typedef struct packed {
		logic [CharW-1:0] ch;
		logic             bad;
	} pfc_res_t;

	function automatic logic [CodeW-1:0] cell_at(input logic [SqW-1:0] sq,
			input logic [CodeW-1:0] k);
		logic [CodeW-1:0] v;
		v = '0;
		for (int i = 0; i < Cells; i++) begin
			if (k == CodeW'(i))
				v = sq[i*CodeW +: CodeW];
		end
		return v;
	endfunction

	// lowest cell holding code, NoCell if none
	function automatic logic [CodeW-1:0] locate(input logic [SqW-1:0] sq,
			input logic [CodeW-1:0] code);
		logic [CodeW-1:0] k;
		k = NoCell;
		for (int i = Cells - 1; i >= 0; i--) begin
			if (sq[i*CodeW +: CodeW] == code)
				k = CodeW'(i);
		end
		return k;
	endfunction

	function automatic logic [2:0] row_of(input logic [CodeW-1:0] k);
		logic [2:0] r;
		if (k >= 5'd20)
			r = 3'd4;
		else if (k >= 5'd15)
			r = 3'd3;
		else if (k >= 5'd10)
			r = 3'd2;
		else if (k >= 5'd5)
			r = 3'd1;
		else
			r = 3'd0;
		return r;
	endfunction

	function automatic logic [2:0] col_of(input logic [CodeW-1:0] k);
		logic [CodeW-1:0] base;
		logic [2:0]       r;
		r    = row_of(k);
		base = CodeW'({r, 2'b00}) + CodeW'(r);
		return 3'(k - base);
	endfunction

	// one step around the row or column, forward or backward
	function automatic logic [2:0] step5(input logic [2:0] v, input logic back);
		logic [2:0] n;
		if (back)
			n = (v == 3'd0) ? 3'd4 : 3'(v - 3'd1);
		else
			n = (v == 3'd4) ? 3'd0 : 3'(v + 3'd1);
		return n;
	endfunction

	function automatic logic [CodeW-1:0] rc_to_idx(input logic [2:0] r,
			input logic [2:0] c);
		return CodeW'({r, 2'b00}) + CodeW'(r) + CodeW'(c);
	endfunction

endpackage

/* rtl/core/pfc_in_if.sv */
// ----------------------------------------------------------------------------
// pfc_in_if
// Text input channel: valid/ready handshake carrying one byte per transfer.
// ----------------------------------------------------------------------------
interface pfc_in_if import pfc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CharW-1:0] in_char;
	logic             end_of_text;

	modport source (output valid, output in_char, output end_of_text, input ready);
	modport sink   (input valid, input in_char, input end_of_text, output ready);
endinterface

/* rtl/core/pfc_out_if.sv */
// ----------------------------------------------------------------------------
// pfc_out_if
// Result channel: valid/ready handshake carrying one result letter per transfer.
// ----------------------------------------------------------------------------
interface pfc_out_if import pfc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CharW-1:0] out_char;
	logic             bad_char;
	logic             run_last;

	modport source (output valid, output out_char, output bad_char, output run_last,
		input ready);
	modport sink   (input valid, input out_char, input bad_char, input run_last,
		output ready);
endinterface

/* rtl/core/playfair_digraph_cipher.sv */
// ----------------------------------------------------------------------------
// playfair_digraph_cipher
// Streaming Playfair encrypt/decrypt over a configurable 5x5 key square.
// ----------------------------------------------------------------------------
// The block takes one text byte per transfer into an input register and
// works out, from that register, every result that byte causes (zero to
// four letters, or one error) in a single pass of locate/transform logic.
// Those results go into a four-entry result buffer that drains one per cycle
// while the result port is ready, and the next byte is taken while the
// buffer still holds results. An input transfer can happen in every cycle
// while the buffer can take the results, so the throughput is set by the
// result port. A byte's results are registered in the result buffer before
// they reach the result port. The user must write key square and mode over
// the APB port only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher import pfc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	pfc_in_if.sink           text_in,
	pfc_out_if.source        text_out,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready
);

	// configuration
	logic             mode_q;
	logic [HalfW-1:0] sq_low_q;
	logic [HalfW-1:0] sq_mid_q;
	logic [CodeW-1:0] sq_last_q;
	logic [SqW-1:0]   square;
	logic             cfg_wr;
	logic [1:0]       reg_sel;

	// input register
	logic             vld_s1;
	logic [CharW-1:0] char_s1;
	logic             eot_s1;

	// pending letter
	logic             pend_v_q;
	logic [CodeW-1:0] pend_q;

	// result buffer
	pfc_res_t         res_q [MaxRes];
	logic [CntW-1:0]  rem_q;
	logic [IdxW-1:0]  idx_q;

	logic             is_letter, ok_in, enc, dup, dg_ok, err;
	logic [CodeW-1:0] code_raw, code, loc_c, loc_p, loc_x, a_idx, b_idx;
	logic [2:0]       ra, ca, rb, cb;
	logic [CodeW-1:0] oa, ob;
	logic [1:0]       copies;
	logic [CntW-1:0]  res_cnt;
	logic             new_pv;
	pfc_res_t         res_a, res_b, res_err;
	pfc_res_t         res_n [MaxRes];
	logic             out_take, buf_free_next, s1_take, load;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign reg_sel = paddr[4:3];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign square  = {sq_last_q, sq_mid_q, sq_low_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			sq_low_q  <= '0;
			sq_mid_q  <= '0;
			sq_last_q <= '0;
		end else if (cfg_wr) begin
			case (reg_sel)
				RegMode: mode_q    <= pwdata[0];
				RegLow:  sq_low_q  <= pwdata[HalfW-1:0];
				RegMid:  sq_mid_q  <= pwdata[HalfW-1:0];
				RegLast: sq_last_q <= pwdata[CodeW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			RegMode: prdata = DataW'(mode_q);
			RegLow:  prdata = DataW'(sq_low_q);
			RegMid:  prdata = DataW'(sq_mid_q);
			RegLast: prdata = DataW'(sq_last_q);
			default: prdata = '0;
		endcase
	end

	// ---------------- handshake control ----------------
	assign out_take      = text_out.valid && text_out.ready;
	assign buf_free_next = (rem_q == '0) || ((rem_q == CntW'(1)) && text_out.ready);
	assign s1_take       = vld_s1 && ((res_cnt == '0) || buf_free_next);
	assign load          = s1_take && (res_cnt != '0);
	assign text_in.ready = !vld_s1 || s1_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (text_in.ready)
			vld_s1 <= text_in.valid;
	end

	always_ff @(posedge clk) begin
		if (text_in.ready) begin
			char_s1 <= text_in.in_char;
			eot_s1  <= text_in.end_of_text;
		end
	end

	// ---------------- digraph logic ----------------
	assign enc       = !mode_q;
	assign is_letter = (char_s1 >= AsciiA) && (char_s1 <= AsciiZ);
	assign code_raw  = CodeW'(char_s1 - AsciiA);
	assign code      = (enc && code_raw == LetterJ) ? LetterI : code_raw;
	assign loc_c     = locate(square, code);
	assign loc_p     = locate(square, pend_q);
	assign loc_x     = locate(square, LetterX);
	assign ok_in     = is_letter && (loc_c != NoCell);
	assign dup       = pend_v_q && (pend_q == code);

	// first letter is the held one when there is one; x fills in encrypt mode
	assign a_idx = pend_v_q ? loc_p : loc_c;
	assign b_idx = (enc && (dup || !pend_v_q)) ? loc_x : loc_c;
	assign dg_ok = (a_idx != NoCell) && (b_idx != NoCell);

	assign ra = row_of(a_idx);
	assign ca = col_of(a_idx);
	assign rb = row_of(b_idx);
	assign cb = col_of(b_idx);

	always_comb begin
		if (ra == rb) begin
			oa = rc_to_idx(ra, step5(ca, mode_q));
			ob = rc_to_idx(rb, step5(cb, mode_q));
		end else if (ca == cb) begin
			oa = rc_to_idx(step5(ra, mode_q), ca);
			ob = rc_to_idx(step5(rb, mode_q), cb);
		end else begin
			oa = rc_to_idx(ra, cb);
			ob = rc_to_idx(rb, ca);
		end
	end

	assign res_a   = '{ch: AsciiA + CharW'(cell_at(square, oa)), bad: 1'b0};
	assign res_b   = '{ch: AsciiA + CharW'(cell_at(square, ob)), bad: 1'b0};
	assign res_err = '{ch: '0, bad: 1'b1};

	// how many copies of the digraph this byte emits, and the next held letter
	always_comb begin
		copies = 2'd0;
		err    = 1'b0;
		new_pv = pend_v_q;
		if (!ok_in) begin
			err    = 1'b1;
			new_pv = 1'b0;
		end else if (enc) begin
			if (pend_v_q) begin
				if (dup) begin
					copies = eot_s1 ? 2'd2 : 2'd1;
					new_pv = !eot_s1;
				end else begin
					copies = 2'd1;
					new_pv = 1'b0;
				end
			end else begin
				copies = eot_s1 ? 2'd1 : 2'd0;
				new_pv = !eot_s1;
			end
		end else begin
			if (pend_v_q) begin
				copies = 2'd1;
				new_pv = 1'b0;
			end else begin
				new_pv = !eot_s1;
			end
		end
		if (copies != 2'd0 && !dg_ok) begin
			copies = 2'd0;
			err    = 1'b1;
			new_pv = 1'b0;
		end
	end

	assign res_cnt  = CntW'({copies, 1'b0}) + CntW'(err);
	assign res_n[0] = (copies == 2'd0) ? res_err : res_a;
	assign res_n[1] = res_b;
	assign res_n[2] = res_a;
	assign res_n[3] = res_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			pend_q   <= '0;
		end else if (s1_take) begin
			pend_v_q <= new_pv;
			if (!new_pv)
				pend_q <= '0;
			else if (!pend_v_q)
				pend_q <= code;
		end
	end

	// ---------------- result buffer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			rem_q <= res_cnt;
			idx_q <= '0;
		end else if (out_take) begin
			rem_q <= rem_q - CntW'(1);
			idx_q <= idx_q + IdxW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < MaxRes; i++)
				res_q[i] <= res_n[i];
		end
	end

	assign text_out.valid    = (rem_q != '0);
	assign text_out.out_char = res_q[idx_q].ch;
	assign text_out.bad_char = res_q[idx_q].bad;
	assign text_out.run_last = (rem_q == CntW'(1));

`ifndef SYNTHESIS
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= CntW'(MaxRes))
		else $error("result count out of range");

	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> rem_q == $past(res_cnt))
		else $error("result buffer not loaded with item count");

	a_err_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_take && err) |=> (!pend_v_q && pend_q == '0))
		else $error("held letter survived an error result");

	a_dec_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_take && mode_q) |-> res_cnt <= CntW'(2))
		else $error("decrypt emitted more than one digraph");
`endif

endmodule
